>>> sv/bpfu_pkg.sv
// Package for the bit-packed field unpacker: result and status types,
// width constants and the effective entry width helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpfu_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SKIP_W   = 3;
    localparam int unsigned CFG_W    = 4;
    localparam int unsigned VALUE_W  = 15;
    localparam int unsigned INDEX_W  = 4;
    localparam int unsigned ACC_W    = 23;
    localparam int unsigned HELD_W   = 5;

    localparam logic [CFG_W-1:0]  ENTRY_W_MIN   = 4'd9;
    localparam logic [CFG_W-1:0]  ENTRY_W_RESET = 4'd9;
    localparam logic [HELD_W-1:0] HELD_MAX      = 5'd14;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [HELD_W-1:0] bits_held;
    } status_t;

    function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] cfg);
        eff_width = (cfg < ENTRY_W_MIN) ? ENTRY_W_MIN : cfg;
    endfunction

    function automatic logic [VALUE_W-1:0] width_mask(input logic [CFG_W-1:0] w);
        width_mask = ~({VALUE_W{1'b1}} << w);
    endfunction

endpackage

`default_nettype wire

>>> sv/bpfu_unpack.sv
// Unpack stage: bit accumulator, held-bit count and entry index, plus the
// shift-and-mask extraction of at most one entry per byte. Depends on bpfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpfu_unpack
    import bpfu_pkg::*;
#(
    parameter int unsigned ENTRIES_PER_BLOCK = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              block_start,
    input  wire logic [SKIP_W-1:0] start_bit,
    input  wire logic [CFG_W-1:0]  entry_width,
    output logic                   emit,
    output result_t                result,
    output status_t                status
);

    localparam int unsigned IDX_W = (ENTRIES_PER_BLOCK > 1) ? $clog2(ENTRIES_PER_BLOCK) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES_PER_BLOCK - 1);

    logic [ACC_W-1:0]  acc_reg,  acc_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic [IDX_W-1:0]  idx_reg,  idx_next;

    logic [CFG_W-1:0]  w;
    logic [ACC_W-1:0]  base_acc;
    logic [HELD_W-1:0] base_held;
    logic [IDX_W-1:0]  base_idx;
    logic [BYTE_W-1:0] sbyte;
    logic [HELD_W-1:0] new_bits;
    logic [ACC_W-1:0]  acc_sum;
    logic [HELD_W-1:0] held_sum;
    logic              is_last;

    always_comb
    begin
        w         = eff_width(entry_width);
        base_acc  = block_start ? '0 : acc_reg;
        base_held = block_start ? '0 : held_reg;
        base_idx  = block_start ? '0 : idx_reg;
        sbyte     = block_start ? (data_byte >> start_bit) : data_byte;
        new_bits  = block_start ? (HELD_W'(BYTE_W) - HELD_W'(start_bit)) : HELD_W'(BYTE_W);
        acc_sum   = base_acc | (ACC_W'(sbyte) << base_held[3:0]);
        held_sum  = base_held + new_bits;
        emit      = (held_sum >= HELD_W'(w));
        is_last   = (base_idx >= IDX_LAST);

        result.value = acc_sum[VALUE_W-1:0] & width_mask(w);
        result.index = INDEX_W'(base_idx);
        result.last  = is_last;

        if (emit)
        begin
            acc_next  = acc_sum >> w;
            held_next = held_sum - HELD_W'(w);
            idx_next  = is_last ? '0 : base_idx + IDX_W'(1);
        end
        else
        begin
            acc_next  = acc_sum;
            held_next = held_sum;
            idx_next  = base_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            held_reg <= '0;
            idx_reg  <= '0;
        end
        else if (step)
        begin
            acc_reg  <= acc_next;
            held_reg <= held_next;
            idx_reg  <= idx_next;
        end
    end

    assign status.bits_held = held_reg;

endmodule

`default_nettype wire

>>> sv/bpfu_out_reg.sv
// Result register with valid/ready: holds one result beat and takes a new
// one in the same cycle the held beat leaves. Depends on bpfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpfu_out_reg
    import bpfu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t load_data,
    output logic         can_load,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> sv/bit_packed_field_unpacker_core.sv
// Top level of the bit-packed field unpacker: input beat register, entry
// width register, unpack stage and result register.
// Depends on bpfu_pkg, bpfu_unpack, bpfu_out_reg.
//
//  channel   signals                                  handshake
//  input     data_byte, block_start, start_bit        in_valid / in_ready
//  result    entry_value, entry_index, last_of_block  out_valid / out_ready
//  config    cfg_wr_data (entry width)                cfg_wr_en, no wait
//
// One byte per cycle sustained while the result register can load; the rate
// is set by the single accumulator update per byte. A byte waits in the
// input register until it can be unpacked into the result register.
// Reset clears the accumulator, bit count, entry index and all valid flags;
// the entry width returns to 9. Stalls on out_ready hold the input register,
// and in_ready stays high while the held byte can move on.
`timescale 1ns / 1ps
`default_nettype none

module bit_packed_field_unpacker_core
    import bpfu_pkg::*;
#(
    parameter int unsigned ENTRIES_PER_BLOCK = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [BYTE_W-1:0]  data_byte,
    input  wire logic               block_start,
    input  wire logic [SKIP_W-1:0]  start_bit,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [VALUE_W-1:0]      entry_value,
    output logic [INDEX_W-1:0]      entry_index,
    output logic                    last_of_block,
    input  wire logic               cfg_wr_en,
    input  wire logic [CFG_W-1:0]   cfg_wr_data
);

    logic [CFG_W-1:0]  width_reg;
    logic              in_vld_reg, in_vld_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              start_reg;
    logic [SKIP_W-1:0] skip_reg;

    logic    step;
    logic    emit;
    logic    can_load;
    result_t result;
    result_t out_data;
    status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            width_reg <= ENTRY_W_RESET;
        else if (cfg_wr_en)
            width_reg <= cfg_wr_data;
    end

    assign step        = in_vld_reg && can_load;
    assign in_ready    = !in_vld_reg || step;
    assign in_vld_next = (in_valid && in_ready) || (in_vld_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= data_byte;
            start_reg <= block_start;
            skip_reg  <= start_bit;
        end
    end

    bpfu_unpack #(
        .ENTRIES_PER_BLOCK (ENTRIES_PER_BLOCK)
    ) u_unpack (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .data_byte   (byte_reg),
        .block_start (start_reg),
        .start_bit   (skip_reg),
        .entry_width (width_reg),
        .emit        (emit),
        .result      (result),
        .status      (status)
    );

    bpfu_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && emit),
        .load_data (result),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign entry_value   = out_data.value;
    assign entry_index   = out_data.index;
    assign last_of_block = out_data.last;

`ifndef ASSERT_OFF
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.bits_held <= HELD_MAX)
        else $error("bit count above 14");

    a_value_masked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((entry_value & ~width_mask(eff_width(width_reg))) == '0))
        else $error("entry wider than configured width");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_of_block) |->
            (entry_index == INDEX_W'(ENTRIES_PER_BLOCK - 1)))
        else $error("last beat at wrong index");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !can_load) |=> in_vld_reg)
        else $error("stalled byte lost");
`endif

endmodule

`default_nettype wire
